/* hw/rtl/bhpq_pkg.sv */
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared constants, types and the ranking function of the heap queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam int CAPACITY = 255;
	localparam int KEY_W    = 32;
	localparam int COUNT_W  = 8;
	localparam int ADDR_W   = $clog2(CAPACITY + 1);
	localparam int IDX_W    = ADDR_W + 1;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [PADDR_W-3:0] REG_PRIORITY_ORDER = '0;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CMP,
		S_RM_LAST,
		S_RM_MOVED,
		S_DN_L,
		S_DN_R,
		S_DN_CMP,
		S_WR,
		S_FIN
	} state_t;

	typedef struct packed {
		logic             operation;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0]    removed_key;
		logic                removed_valid;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
	} rsp_t;

	// true when a strictly outranks b
	function automatic logic outranks(logic order, logic [KEY_W-1:0] a,
			logic [KEY_W-1:0] b);
		return order ? (a < b) : (a > b);
	endfunction

endpackage

/* hw/rtl/bhpq_ifs.sv */
// ----------------------------------------------------------------------------
// bhpq_ifs
// Valid/ready channels of the heap queue: request and response.
// ----------------------------------------------------------------------------
interface bhpq_in_if;
	import bhpq_pkg::*;

	logic             valid;
	logic             ready;
	logic             operation;
	logic [KEY_W-1:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink (input valid, input operation, input key, output ready);
endinterface

interface bhpq_out_if;
	import bhpq_pkg::*;

	logic                valid;
	logic                ready;
	logic [KEY_W-1:0]    removed_key;
	logic                removed_valid;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;

	modport source (output valid, output removed_key, output removed_valid,
		output status, output count, output is_empty, input ready);
	modport sink (input valid, input removed_key, input removed_valid,
		input status, input count, input is_empty, output ready);
endinterface

/* hw/rtl/bhpq_core.sv */
// ----------------------------------------------------------------------------
// bhpq_core
// Heap store, element count and the sift sequencer around one comparator.
// ----------------------------------------------------------------------------
module bhpq_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bhpq_pkg::req_t  req,
	input  logic            order,
	input  logic            out_free,
	output logic            idle,
	output logic            res_valid,
	output bhpq_pkg::rsp_t  res
);
	import bhpq_pkg::*;

	state_t state_q, state_d;

	logic [COUNT_W-1:0]  count_q;
	logic [ADDR_W-1:0]   pos_q;
	logic [ADDR_W-1:0]   kid_q;
	logic [ADDR_W-1:0]   best_idx_q;
	logic [KEY_W-1:0]    hold_q;
	logic [KEY_W-1:0]    left_q;
	logic [KEY_W-1:0]    best_q;
	logic [KEY_W-1:0]    removed_q;
	logic                rvalid_q;
	logic [STATUS_W-1:0] status_q;

	logic [KEY_W-1:0] mem [CAPACITY+1];
	logic [KEY_W-1:0] rd_data_q;
	logic             rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic             wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [KEY_W-1:0] wr_data;

	logic [KEY_W-1:0] cmp_a;
	logic [KEY_W-1:0] cmp_b;
	logic             cmp_hit;

	logic             ins_ok;
	logic             rem_ok;
	logic [ADDR_W-1:0] ins_pos;
	logic [ADDR_W-1:0] up_addr;
	logic [IDX_W-1:0] dn_kid;
	logic             dn_kid_ok;
	logic             right_ok;

	assign ins_ok    = (req.operation == OP_INSERT) && (count_q < COUNT_W'(CAPACITY));
	assign rem_ok    = (req.operation == OP_REMOVE) && (count_q != '0);
	assign ins_pos   = ADDR_W'(count_q) + ADDR_W'(1);
	assign up_addr   = pos_q >> 1;
	assign dn_kid    = {best_idx_q, 1'b0};
	assign dn_kid_ok = dn_kid <= IDX_W'(count_q);
	assign right_ok  = kid_q < ADDR_W'(count_q);

	// shared comparator
	always_comb begin
		cmp_a = best_q;
		cmp_b = hold_q;
		case (state_q)
			S_UP_CMP: begin
				cmp_a = hold_q;
				cmp_b = rd_data_q;
			end
			S_DN_R: begin
				cmp_a = rd_data_q;
				cmp_b = left_q;
			end
			default: begin
				cmp_a = best_q;
				cmp_b = hold_q;
			end
		endcase
	end

	assign cmp_hit = outranks(order, cmp_a, cmp_b);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (ins_ok && count_q != '0)
						state_d = S_UP_CMP;
					else if (rem_ok)
						state_d = S_RM_LAST;
					else
						state_d = S_FIN;
				end
			end
			S_UP_CMP: begin
				if (!cmp_hit)
					state_d = S_FIN;
				else if (up_addr == ADDR_W'(1))
					state_d = S_WR;
			end
			S_RM_LAST:  state_d = S_RM_MOVED;
			S_RM_MOVED: state_d = (count_q >= COUNT_W'(2)) ? S_DN_L : S_WR;
			S_DN_L:     state_d = right_ok ? S_DN_R : S_DN_CMP;
			S_DN_R:     state_d = S_DN_CMP;
			S_DN_CMP: begin
				if (!cmp_hit)
					state_d = S_FIN;
				else
					state_d = dn_kid_ok ? S_DN_L : S_WR;
			end
			S_WR:  state_d = S_FIN;
			S_FIN: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = hold_q;
		case (state_q)
			S_IDLE: begin
				if (start && ins_ok) begin
					if (count_q == '0) begin
						wr_en   = 1'b1;
						wr_addr = ADDR_W'(1);
						wr_data = req.key;
					end else begin
						rd_en   = 1'b1;
						rd_addr = ins_pos >> 1;
					end
				end else if (start && rem_ok) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(1);
				end
			end
			S_UP_CMP: begin
				wr_en   = 1'b1;
				wr_data = cmp_hit ? rd_data_q : hold_q;
				rd_en   = cmp_hit;
				rd_addr = up_addr >> 1;
			end
			S_RM_LAST: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(count_q) + ADDR_W'(1);
			end
			S_RM_MOVED: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(2);
			end
			S_DN_L: begin
				rd_en   = right_ok;
				rd_addr = kid_q + ADDR_W'(1);
			end
			S_DN_CMP: begin
				wr_en   = 1'b1;
				wr_data = cmp_hit ? best_q : hold_q;
				rd_en   = cmp_hit && dn_kid_ok;
				rd_addr = dn_kid[ADDR_W-1:0];
			end
			S_WR: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				if (ins_ok)
					count_q <= count_q + COUNT_W'(1);
				else if (rem_ok)
					count_q <= count_q - COUNT_W'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					hold_q    <= req.key;
					pos_q     <= ins_pos;
					removed_q <= '0;
					rvalid_q  <= rem_ok;
					if (req.operation == OP_INSERT)
						status_q <= ins_ok ? STAT_OK : STAT_FULL;
					else
						status_q <= rem_ok ? STAT_OK : STAT_EMPTY;
				end
			end
			S_UP_CMP: begin
				if (cmp_hit)
					pos_q <= up_addr;
			end
			S_RM_LAST: begin
				removed_q <= rd_data_q;
			end
			S_RM_MOVED: begin
				hold_q <= rd_data_q;
				pos_q  <= ADDR_W'(1);
				kid_q  <= ADDR_W'(2);
			end
			S_DN_L: begin
				left_q     <= rd_data_q;
				best_q     <= rd_data_q;
				best_idx_q <= kid_q;
			end
			S_DN_R: begin
				best_q     <= cmp_hit ? rd_data_q : left_q;
				best_idx_q <= cmp_hit ? kid_q + ADDR_W'(1) : kid_q;
			end
			S_DN_CMP: begin
				if (cmp_hit) begin
					pos_q <= best_idx_q;
					kid_q <= dn_kid[ADDR_W-1:0];
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN) && out_free;

	assign res.removed_key   = removed_q;
	assign res.removed_valid = rvalid_q;
	assign res.status        = status_q;
	assign res.count         = count_q;
	assign res.is_empty      = (count_q == '0);

endmodule

/* hw/rtl/binary_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Priority queue of unsigned keys held as a binary heap in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per operation: insert a key, or remove the
//   highest-ranked key. rsp returns one beat per request with the removed
//   key, a status code and the element count after the operation.
//   priority_order (APB, byte address 0) picks larger-first (0) or
//   smaller-first (1); write it only while the queue is idle.
//   All sifting shares a single compare unit. An insert climbs one level
//   per S_UP_CMP step; a remove reads the root and the last key, then
//   descends one level per S_DN_L, S_DN_R (if a right child), S_DN_CMP round.
//   req.ready is high only while no request is in progress.
//   Reset empties the queue and selects larger-first; the heap memory is
//   not cleared, since data read from unwritten slots is never used.
//   A stalled rsp holds its beat in the output register; the next request
//   may start meanwhile and finishes once that register frees up.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bhpq_pkg::PADDR_W-1:0]   paddr,
	input  logic [bhpq_pkg::PDATA_W-1:0]   pwdata,
	output logic [bhpq_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	bhpq_in_if.sink                        req,
	bhpq_out_if.source                     rsp
);
	import bhpq_pkg::*;

	logic   order_q;
	logic   out_valid_q;
	rsp_t   rsp_q;
	req_t   core_req;
	rsp_t   core_res;
	logic   core_idle;
	logic   core_res_valid;
	logic   out_free;
	logic   start;

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_PRIORITY_ORDER) ?
		PDATA_W'(order_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
				paddr[PADDR_W-1:2] == REG_PRIORITY_ORDER) begin
			order_q <= pwdata[0];
		end
	end

	assign req.ready          = core_idle;
	assign start              = req.valid && core_idle;
	assign core_req.operation = req.operation;
	assign core_req.key       = req.key;
	assign out_free           = !out_valid_q || rsp.ready;

	bhpq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (core_req),
		.order     (order_q),
		.out_free  (out_free),
		.idle      (core_idle),
		.res_valid (core_res_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= core_res_valid;
	end

	always_ff @(posedge clk) begin
		if (core_res_valid)
			rsp_q <= core_res;
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.removed_key   = rsp_q.removed_key;
	assign rsp.removed_valid = rsp_q.removed_valid;
	assign rsp.status        = rsp_q.status;
	assign rsp.count         = rsp_q.count;
	assign rsp.is_empty      = rsp_q.is_empty;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a previous one is in progress");

	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.removed_valid |-> rsp.status == STAT_OK)
		else $error("removed key reported with error status");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.is_empty == (rsp.count == '0))
		else $error("empty flag disagrees with count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_FULL |-> rsp.count == COUNT_W'(CAPACITY))
		else $error("full status below capacity");
`endif

endmodule
